>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Concurrent assertion on the block clock and reset
`define ASSERT_PROP(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/core/f2mf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package f2mf_pkg;

  // Single-precision exponent field landmarks
  localparam logic [7:0] ExpAllOnes = 8'hFF;
  localparam logic [7:0] ExpOvfMin  = 8'd131;  // unbiased exponent 4 and up
  localparam logic [7:0] ExpNormMin = 8'd125;  // unbiased exponent -2
  localparam logic [7:0] ExpSubMin  = 8'd119;  // smallest exponent not flushed
  localparam logic [7:0] ExpNormOfs = 8'd124;  // efield - 124 = minifloat exponent
  localparam logic [7:0] SubShBase  = 8'd144;  // alignment shift = 144 - efield

  localparam logic [4:0] NormShift  = 5'd19;
  localparam int unsigned SigW      = 24;
  localparam logic [7:0] QOffset    = 8'd16;

  // Magnitude codes of the minifloat
  localparam logic [6:0] MagInf     = 7'h70;
  localparam logic [6:0] MagNan     = 7'h71;
  localparam logic [6:0] MagZero    = 7'h00;

  // Class of an input word
  typedef enum logic [2:0] {
    KIND_ZERO = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_NORM = 3'd2,
    KIND_INF  = 3'd3,
    KIND_NAN  = 3'd4
  } kind_e;

  // Decoded item after the first stage
  typedef struct packed {
    logic              sign;
    kind_e             kind;
    logic [4:0]        shamt;
    logic [SigW-1:0]   sig;
    logic [2:0]        expb;
  } dec_t;

  // Aligned item after the second stage
  typedef struct packed {
    logic       sign;
    kind_e      kind;
    logic [4:0] q;
    logic       guard;
    logic       sticky;
    logic [2:0] expb;
  } aln_t;

endpackage

`default_nettype wire

>>> rtl/core/float32_to_minifloat_convert.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------
// input    | in        | in_valid_i / in_ready_o | float_bits_i [31:0]
// output   | out       | out_valid_o/ out_ready_i| mini_bits_o  [7:0]
//
// Three register stages: decode, align, round and pack; throughput one item per
// cycle when the output is taken.
// Each stage advances when the stage after it is empty or advancing, so a
// stalled output fills the pipe and then holds in_ready_o low; nothing is lost.
// Reset clears the stage valid bits only; the payload registers are not reset.

module float32_to_minifloat_convert (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] float_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       mini_bits_o
);
  import f2mf_pkg::*;

  logic        s1_valid_q, s2_valid_q, s3_valid_q;
  logic        s1_rdy, s2_rdy, s3_rdy;
  dec_t        dec_d, dec_q;
  aln_t        aln_d, aln_q;
  logic [7:0]  mini_d, mini_q;

  logic [7:0]  efield;
  logic [22:0] mant;
  logic [7:0]  sh_full;
  logic [7:0]  expb_full;

  logic [SigW-1:0] shifted;
  logic [4:0]      shm1;
  logic [SigW:0]   sig_x;
  logic [SigW:0]   low_mask;

  logic       inc;
  logic [5:0] qr;
  logic [7:0] code;

  // Advance a stage when the next one is empty or advancing
  assign s3_rdy     = !s3_valid_q || out_ready_i;
  assign s2_rdy     = !s2_valid_q || s3_rdy;
  assign s1_rdy     = !s1_valid_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  // Stage 1: classify and pick the alignment shift
  assign efield    = float_bits_i[30:23];
  assign mant      = float_bits_i[22:0];
  assign sh_full   = SubShBase - efield;
  assign expb_full = efield - ExpNormOfs;

  always_comb begin
    dec_d.sign  = float_bits_i[31];
    dec_d.sig   = {1'b1, mant};
    dec_d.shamt = NormShift;
    dec_d.expb  = expb_full[2:0];
    if (efield == ExpAllOnes) begin
      dec_d.kind = (mant != '0) ? KIND_NAN : KIND_INF;
    end else if (efield >= ExpOvfMin) begin
      dec_d.kind = KIND_INF;
    end else if (efield >= ExpNormMin) begin
      dec_d.kind = KIND_NORM;
    end else if (efield >= ExpSubMin) begin
      dec_d.kind  = KIND_SUB;
      dec_d.shamt = sh_full[4:0];
    end else begin
      dec_d.kind = KIND_ZERO;
    end
  end

  // Stage 2: align the significand and collect guard and sticky bits;
  // one extra zero bit on top keeps the guard of the widest shift at zero
  assign shifted  = dec_q.sig >> dec_q.shamt;
  assign shm1     = dec_q.shamt - 5'd1;
  assign sig_x    = {1'b0, dec_q.sig};
  assign low_mask = ({{SigW{1'b0}}, 1'b1} << shm1) - {{SigW{1'b0}}, 1'b1};

  always_comb begin
    aln_d.sign   = dec_q.sign;
    aln_d.kind   = dec_q.kind;
    aln_d.expb   = dec_q.expb;
    aln_d.q      = shifted[4:0];
    aln_d.guard  = sig_x[shm1];
    aln_d.sticky = |(sig_x & low_mask);
  end

  // Stage 3: round to nearest even and pack
  assign inc  = aln_q.guard && (aln_q.sticky || aln_q.q[0]);
  assign qr   = {1'b0, aln_q.q} + {5'd0, inc};
  assign code = {1'b0, aln_q.expb, 4'd0} + {2'd0, qr} - QOffset;

  always_comb begin
    case (aln_q.kind)
      KIND_NAN:  mini_d = {aln_q.sign, MagNan};
      KIND_INF:  mini_d = {aln_q.sign, MagInf};
      KIND_NORM: begin
        if (code >= {1'b0, MagInf}) begin
          mini_d = {aln_q.sign, MagInf};
        end else begin
          mini_d = {aln_q.sign, code[6:0]};
        end
      end
      KIND_SUB:  mini_d = {aln_q.sign, 1'b0, qr};
      default:   mini_d = {aln_q.sign, MagZero};
    endcase
  end

  // Hold valid bits under reset, advance them with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_q <= in_valid_i;
      if (s2_rdy) s2_valid_q <= s1_valid_q;
      if (s3_rdy) s3_valid_q <= s2_valid_q;
    end
  end

  // Load payload on each stage transfer
  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) dec_q  <= dec_d;
    if (s2_rdy && s1_valid_q) aln_q  <= aln_d;
    if (s3_rdy && s2_valid_q) mini_q <= mini_d;
  end

  assign out_valid_o = s3_valid_q;
  assign mini_bits_o = mini_q;

endmodule

`default_nettype wire

>>> rtl/core/f2mf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module f2mf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [31:0] float_bits_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  mini_bits_o
);
  import f2mf_pkg::*;

  logic nan_in;
  logic in_xfer;

  assign nan_in  = (float_bits_i[30:23] == ExpAllOnes) && (float_bits_i[22:0] != 23'd0);
  assign in_xfer = in_valid_i && in_ready_o;

  // Stalled result holds
  `ASSERT_PROP(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(mini_bits_o))

  // Input backs up only when the whole pipe is full and stalled
  `ASSERT_PROP(a_ready_full, !in_ready_o |-> out_valid_o && !out_ready_i)

  // Free-flowing output gives a result once a transfer has passed the decode, align and pack registers
  `ASSERT_PROP(a_latency, in_xfer ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)

  // Exponent field 7 only carries infinity or NaN
  `ASSERT_PROP(a_top_field, out_valid_o && (mini_bits_o[6:4] == 3'd7) |-> mini_bits_o[3:1] == 3'd0)

  // A NaN transfer with free output comes out as NaN
  `ASSERT_PROP(a_nan, (in_xfer && nan_in) ##1 out_ready_i ##1 out_ready_i |=> mini_bits_o[6:0] == MagNan)

endmodule

bind float32_to_minifloat_convert f2mf_checker u_f2mf_checker (.*);

`default_nettype wire
